// File: src/usrng_pkg.sv
// types, constants and helper functions shared by the ultrasonic ranger
`default_nettype none

package usrng_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int ADC_WIDTH   = 12;

  localparam int TRIG_W    = 8;
  localparam int SCALE_W   = 16;
  localparam int SCALE_FRAC = 16;
  localparam int DIST_W    = 11;
  localparam int THR_W     = 9;
  localparam int SEG_W     = 7;
  localparam int REM_W     = 10;
  localparam int DIGIT_W   = 4;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  localparam int PROD_W      = COUNT_WIDTH + SCALE_W;
  localparam int DIV_W       = ADC_WIDTH + 32;
  localparam int DIV10_SHIFT = 35;
  localparam logic [31:0] DIV10_MUL = 32'hCCCC_CCCD;

  localparam int DIST_MAX = 2047;
  localparam int THR_MAX  = 511;

  localparam logic [TRIG_W-1:0]  TRIG_RESET  = TRIG_W'(15);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1121);
  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(30);
  localparam logic [SEG_W-1:0]   SEG_DASH    = 7'h40;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_BUTTON = 2'd1,
    OP_ADC    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TRIG  = 2'd1,
    PH_WAIT  = 2'd2,
    PH_COUNT = 2'd3
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIGGER = 1'd0,
    CFG_SCALE   = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic                   trig;
    logic                   mode_led;
    logic                   meas;
    logic                   thr_load;
    logic [COUNT_WIDTH-1:0] count;
    logic [ADC_WIDTH-1:0]   adc;
  } ctrl_item_t;

  typedef struct packed {
    logic              trig;
    logic              mode_led;
    logic              alarm;
    logic              done;
    logic [DIST_W-1:0] distance;
    logic [REM_W-1:0]  rem;
  } disp_item_t;

  function automatic logic [SEG_W-1:0] seg_digit(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: src/usrng_in_if.sv
// request channel carrying ticks, button presses and adc samples
`default_nettype none

interface usrng_in_if;
  import usrng_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic                 echo_level;
  logic [ADC_WIDTH-1:0] adc_sample;

  modport source (output valid, output opcode, output echo_level, output adc_sample,
                  input ready);
  modport sink   (input valid, input opcode, input echo_level, input adc_sample,
                  output ready);
endinterface

`default_nettype wire

// File: src/usrng_out_if.sv
// result channel carrying trigger, display and alarm state
`default_nettype none

interface usrng_out_if;
  import usrng_pkg::*;

  logic              valid;
  logic              ready;
  logic              trigger_out;
  logic              mode_led;
  logic              alarm;
  logic [DIST_W-1:0] shown_distance;
  logic [SEG_W-1:0]  seg_hundreds;
  logic [SEG_W-1:0]  seg_tens;
  logic [SEG_W-1:0]  seg_units;
  logic [SEG_W-1:0]  seg_fourth;
  logic              measure_done;

  modport source (output valid, output trigger_out, output mode_led, output alarm,
                  output shown_distance, output seg_hundreds, output seg_tens,
                  output seg_units, output seg_fourth, output measure_done,
                  input ready);
  modport sink   (input valid, input trigger_out, input mode_led, input alarm,
                  input shown_distance, input seg_hundreds, input seg_tens,
                  input seg_units, input seg_fourth, input measure_done,
                  output ready);
endinterface

`default_nettype wire

// File: src/usrng_ctrl.sv
// sonar sequencer: trigger, echo wait and echo count, mode toggle
`default_nettype none

module usrng_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [usrng_pkg::TRIG_W-1:0]   trig_ticks_i,
  usrng_in_if.sink                       in_i,
  output usrng_pkg::ctrl_item_t          item_o,
  output logic                           item_valid_o,
  input  logic                           item_ready_i
);
  import usrng_pkg::*;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] trig_cnt;
  logic                   sonar_q, sonar_d;
  logic                   s1_ready;
  logic                   accept;
  opcode_e                op;
  ctrl_item_t             item_d, item_q;
  logic                   valid_q;

  assign s1_ready   = !valid_q || item_ready_i;
  assign in_i.ready = s1_ready;
  assign accept     = in_i.valid && s1_ready;
  assign op         = opcode_e'(in_i.opcode);
  assign trig_cnt   = (phase_q == PH_IDLE) ? COUNT_WIDTH'(1) : count_q + COUNT_WIDTH'(1);

  // next state
  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    sonar_d = sonar_q;
    if (accept) begin
      unique case (op)
        OP_TICK: begin
          if (sonar_q) begin
            unique case (phase_q)
              PH_IDLE, PH_TRIG: begin
                if (trig_cnt >= COUNT_WIDTH'(trig_ticks_i)) begin
                  phase_d = PH_WAIT;
                  count_d = '0;
                end else begin
                  phase_d = PH_TRIG;
                  count_d = trig_cnt;
                end
              end
              PH_WAIT: begin
                if (in_i.echo_level) begin
                  phase_d = PH_COUNT;
                  count_d = COUNT_WIDTH'(1);
                end
              end
              PH_COUNT: begin
                if (in_i.echo_level) begin
                  if (count_q != '1) begin
                    count_d = count_q + COUNT_WIDTH'(1);
                  end
                end else begin
                  phase_d = PH_IDLE;
                  count_d = '0;
                end
              end
            endcase
          end
        end
        OP_BUTTON: begin
          sonar_d = !sonar_q;
          phase_d = PH_IDLE;
          count_d = '0;
        end
        OP_ADC, OP_NONE: begin
        end
      endcase
    end
  end

  // request record for the datapath
  always_comb begin
    item_d.trig     = sonar_q && (op == OP_TICK) &&
                      ((phase_q == PH_IDLE) || (phase_q == PH_TRIG));
    item_d.meas     = sonar_q && (op == OP_TICK) && (phase_q == PH_COUNT) &&
                      !in_i.echo_level;
    item_d.thr_load = !sonar_q && (op == OP_ADC);
    item_d.mode_led = !sonar_d;
    item_d.count    = count_q;
    item_d.adc      = in_i.adc_sample;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      sonar_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      sonar_q <= sonar_d;
      if (s1_ready) begin
        valid_q <= in_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule

`default_nettype wire

// File: src/usrng_dp.sv
// distance scaling, threshold division, latched distance and alarm
`default_nettype none

module usrng_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [usrng_pkg::SCALE_W-1:0] scale_i,
  input  usrng_pkg::ctrl_item_t         item_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  output usrng_pkg::disp_item_t         disp_o,
  output logic                          disp_valid_o,
  input  logic                          disp_ready_i
);
  import usrng_pkg::*;

  typedef struct packed {
    logic              trig;
    logic              mode_led;
    logic              meas;
    logic              thr_load;
    logic [PROD_W-1:0] prod;
    logic [DIV_W-1:0]  quot;
  } mul_item_t;

  mul_item_t         s2_q;
  logic              s2_v_q;
  logic              s2_ready;
  disp_item_t        s3_d, s3_q;
  logic              s3_v_q;
  logic              s3_ready;
  logic              s3_load;
  logic [PROD_W-1:0] dist_raw;
  logic [DIV_W-1:0]  thr_raw;
  logic [DIST_W-1:0] dist_meas;
  logic [THR_W-1:0]  thr_new;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [THR_W-1:0]  thr_q, thr_d;
  logic              alarm_q, alarm_d;

  assign s3_ready     = !s3_v_q || disp_ready_i;
  assign s2_ready     = !s2_v_q || s3_ready;
  assign item_ready_o = s2_ready;
  assign s3_load      = s3_ready && s2_v_q;

  // multiply stage
  always_ff @(posedge clk_i) begin
    if (s2_ready && item_valid_i) begin
      s2_q.trig     <= item_i.trig;
      s2_q.mode_led <= item_i.mode_led;
      s2_q.meas     <= item_i.meas;
      s2_q.thr_load <= item_i.thr_load;
      s2_q.prod     <= PROD_W'(item_i.count) * PROD_W'(scale_i);
      s2_q.quot     <= DIV_W'(item_i.adc) * DIV_W'(DIV10_MUL);
    end
  end

  // saturate and latch
  assign dist_raw  = s2_q.prod >> SCALE_FRAC;
  assign thr_raw   = s2_q.quot >> DIV10_SHIFT;
  assign dist_meas = (dist_raw > PROD_W'(DIST_MAX)) ? DIST_W'(DIST_MAX) : DIST_W'(dist_raw);
  assign thr_new   = (thr_raw > DIV_W'(THR_MAX)) ? THR_W'(THR_MAX) : THR_W'(thr_raw);

  always_comb begin
    dist_d  = dist_q;
    thr_d   = thr_q;
    alarm_d = alarm_q;
    priority if (s2_q.meas) begin
      dist_d  = dist_meas;
      alarm_d = dist_meas < DIST_W'(thr_q);
    end else if (s2_q.thr_load) begin
      thr_d   = thr_new;
      dist_d  = DIST_W'(thr_new);
      alarm_d = 1'b0;
    end
  end

  always_comb begin
    s3_d.trig     = s2_q.trig;
    s3_d.mode_led = s2_q.mode_led;
    s3_d.alarm    = alarm_d;
    s3_d.done     = s2_q.meas || s2_q.thr_load;
    s3_d.distance = dist_d;
    priority if (dist_d >= DIST_W'(2000)) begin
      s3_d.rem = REM_W'(dist_d - DIST_W'(2000));
    end else if (dist_d >= DIST_W'(1000)) begin
      s3_d.rem = REM_W'(dist_d - DIST_W'(1000));
    end else begin
      s3_d.rem = REM_W'(dist_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      dist_q  <= '0;
      thr_q   <= THR_RESET;
      alarm_q <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_v_q <= item_valid_i;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
      if (s3_load) begin
        dist_q  <= dist_d;
        thr_q   <= thr_d;
        alarm_q <= alarm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_load) begin
      s3_q <= s3_d;
    end
  end

  assign disp_o       = s3_q;
  assign disp_valid_o = s3_v_q;

endmodule

`default_nettype wire

// File: src/usrng_disp.sv
// decimal digit split, seven-segment decode and result register
`default_nettype none

module usrng_disp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  usrng_pkg::disp_item_t disp_i,
  input  logic                  disp_valid_i,
  output logic                  disp_ready_o,
  usrng_out_if.source           out_o
);
  import usrng_pkg::*;

  typedef struct packed {
    logic               trig;
    logic               mode_led;
    logic               alarm;
    logic               done;
    logic [DIST_W-1:0]  distance;
    logic [DIGIT_W-1:0] hund;
    logic [6:0]         low2;
  } digit_item_t;

  digit_item_t        s4_q;
  logic               s4_v_q;
  logic               s4_ready;
  logic               ov_q;
  logic               o_ready;
  logic [15:0]        h_prod;
  logic [DIGIT_W-1:0] hund;
  logic [REM_W-1:0]   h100;
  logic [14:0]        t_prod;
  logic [DIGIT_W-1:0] tens;
  logic [6:0]         t10;
  logic [DIGIT_W-1:0] units;

  logic              trig_q, mode_q, alarm_q, done_q;
  logic [DIST_W-1:0] dist_q;
  logic [SEG_W-1:0]  seg_h_q, seg_t_q, seg_u_q;

  assign o_ready      = !ov_q || out_o.ready;
  assign s4_ready     = !s4_v_q || o_ready;
  assign disp_ready_o = s4_ready;

  // hundreds by reciprocal, valid below one thousand
  assign h_prod = 16'(disp_i.rem) * 16'd41;
  assign hund   = h_prod[15:12];
  assign h100   = REM_W'(hund) * REM_W'(100);

  // tens and units, valid below one hundred
  assign t_prod = 15'(s4_q.low2) * 15'd205;
  assign tens   = t_prod[14:11];
  assign t10    = 7'(tens) * 7'd10;
  assign units  = DIGIT_W'(s4_q.low2 - t10);

  always_ff @(posedge clk_i) begin
    if (s4_ready && disp_valid_i) begin
      s4_q.trig     <= disp_i.trig;
      s4_q.mode_led <= disp_i.mode_led;
      s4_q.alarm    <= disp_i.alarm;
      s4_q.done     <= disp_i.done;
      s4_q.distance <= disp_i.distance;
      s4_q.hund     <= hund;
      s4_q.low2     <= 7'(disp_i.rem - h100);
    end
    if (o_ready && s4_v_q) begin
      trig_q  <= s4_q.trig;
      mode_q  <= s4_q.mode_led;
      alarm_q <= s4_q.alarm;
      done_q  <= s4_q.done;
      dist_q  <= s4_q.distance;
      seg_h_q <= seg_digit(s4_q.hund);
      seg_t_q <= seg_digit(tens);
      seg_u_q <= seg_digit(units);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      if (s4_ready) begin
        s4_v_q <= disp_valid_i;
      end
      if (o_ready) begin
        ov_q <= s4_v_q;
      end
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.trigger_out    = trig_q;
  assign out_o.mode_led       = mode_q;
  assign out_o.alarm          = alarm_q;
  assign out_o.shown_distance = dist_q;
  assign out_o.seg_hundreds   = seg_h_q;
  assign out_o.seg_tens       = seg_t_q;
  assign out_o.seg_units      = seg_u_q;
  assign out_o.seg_fourth     = mode_q ? SEG_DASH : '0;
  assign out_o.measure_done   = done_q;

endmodule

`default_nettype wire

// File: src/ultrasonic_ranger_with_threshold.sv
// top level of the ultrasonic ranger with alarm threshold and segment display
//
// requests arrive on in_i: a timer tick (with the sampled echo level), a mode
// button press or an adc sample. every request gives exactly one result on
// out_o with the trigger drive, mode led, alarm, shown distance in cm and
// the four segment patterns.
// configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (trigger length in ticks, or cm per tick in unsigned q0.16); the user must
// write only while idle, which the block does not enforce. throughput: one
// request per cycle, sustained while out_o is ready, from the five-stage pipe
// (sequencer, multiply, latch, digit split, result register).
// the sequencer state updates as the request is taken, so back-to-back
// ticks time the echo one tick per cycle.
// reset: sonar mode, sequencer idle, threshold 30 cm, distance and alarm
// cleared, trigger length 15, scale 1121, pipe empty.
// a stalled out_o holds its result; stages behind it keep filling and in_i
// ready drops only once all five stages hold results.
`default_nettype none

module ultrasonic_ranger_with_threshold (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [usrng_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [usrng_pkg::CFG_W-1:0]     cfg_wdata_i,
  usrng_in_if.sink                        in_i,
  usrng_out_if.source                     out_o
);
  import usrng_pkg::*;

  logic [TRIG_W-1:0]  trig_ticks_q;
  logic [SCALE_W-1:0] scale_q;
  ctrl_item_t         ctrl_item;
  logic               ctrl_valid;
  logic               ctrl_ready;
  disp_item_t         disp_item;
  logic               disp_valid;
  logic               disp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_ticks_q <= TRIG_RESET;
      scale_q      <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TRIGGER: trig_ticks_q <= cfg_wdata_i[TRIG_W-1:0];
        CFG_SCALE:   scale_q      <= cfg_wdata_i[SCALE_W-1:0];
      endcase
    end
  end

  usrng_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .trig_ticks_i (trig_ticks_q),
    .in_i         (in_i),
    .item_o       (ctrl_item),
    .item_valid_o (ctrl_valid),
    .item_ready_i (ctrl_ready)
  );

  usrng_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .scale_i      (scale_q),
    .item_i       (ctrl_item),
    .item_valid_i (ctrl_valid),
    .item_ready_o (ctrl_ready),
    .disp_o       (disp_item),
    .disp_valid_o (disp_valid),
    .disp_ready_i (disp_ready)
  );

  usrng_disp u_disp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .disp_i       (disp_item),
    .disp_valid_i (disp_valid),
    .disp_ready_o (disp_ready),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire

// File: verif/usrng_checker.sv
// scoreboard for the ultrasonic ranger: predicts each result from the requests and checks it
module usrng_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [usrng_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [usrng_pkg::CFG_W-1:0]     cfg_wdata_i,
  usrng_in_if                             req_if,
  usrng_out_if                            res_if,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import usrng_pkg::*;

  typedef struct packed {
    logic              trig;
    logic              mode_led;
    logic              alarm;
    logic [DIST_W-1:0] distance;
    logic [SEG_W-1:0]  hund;
    logic [SEG_W-1:0]  tens;
    logic [SEG_W-1:0]  units;
    logic [SEG_W-1:0]  fourth;
    logic              done;
  } ranger_view_t;

  logic [TRIG_W-1:0]      trig_len;
  logic [SCALE_W-1:0]     cm_per_tick;
  phase_e                 ph;
  logic [COUNT_WIDTH-1:0] ticks;
  logic                   sonar;
  logic [THR_W-1:0]       thr_cm;
  logic [DIST_W-1:0]      dist_cm;
  logic                   alarm_on;
  ranger_view_t           view_q[$];
  ranger_view_t           want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic logic [SEG_W-1:0] glyph(input int digit);
    case (digit)
      0:       return 7'h3F;
      1:       return 7'h06;
      2:       return 7'h5B;
      3:       return 7'h4F;
      4:       return 7'h66;
      5:       return 7'h6D;
      6:       return 7'h7D;
      7:       return 7'h07;
      8:       return 7'h7F;
      9:       return 7'h6F;
      default: return '0;
    endcase
  endfunction

  function automatic ranger_view_t advance_ranger(input opcode_e op, input logic echo,
                                                  input logic [ADC_WIDTH-1:0] adc);
    ranger_view_t               r;
    logic [2*COUNT_WIDTH-1:0]   prod;
    logic [2*COUNT_WIDTH-1:0]   scaled;
    logic [ADC_WIDTH-1:0]       tenth;
    logic                       trig;
    logic                       done;
    trig = 1'b0;
    done = 1'b0;
    case (op)
      OP_TICK: begin
        if (sonar) begin
          case (ph)
            PH_IDLE, PH_TRIG: begin
              trig  = 1'b1;
              ticks = (ph == PH_IDLE) ? COUNT_WIDTH'(1) : ticks + 1'b1;
              if (ticks >= trig_len) begin
                ph    = PH_WAIT;
                ticks = '0;
              end else begin
                ph = PH_TRIG;
              end
            end
            PH_WAIT: begin
              if (echo) begin
                ticks = COUNT_WIDTH'(1);
                ph    = PH_COUNT;
              end
            end
            default: begin
              if (echo) begin
                if (ticks != '1) ticks = ticks + 1'b1;
              end else begin
                prod     = ticks * cm_per_tick;
                scaled   = prod >> SCALE_FRAC;
                dist_cm  = (scaled > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(scaled);
                alarm_on = dist_cm < thr_cm;
                done     = 1'b1;
                ph       = PH_IDLE;
                ticks    = '0;
              end
            end
          endcase
        end
      end
      OP_BUTTON: begin
        sonar = !sonar;
        ph    = PH_IDLE;
        ticks = '0;
      end
      OP_ADC: begin
        if (!sonar) begin
          tenth    = adc / 10;
          thr_cm   = (tenth > THR_MAX) ? THR_W'(THR_MAX) : THR_W'(tenth);
          dist_cm  = DIST_W'(thr_cm);
          alarm_on = 1'b0;
          done     = 1'b1;
        end
      end
      default: ;
    endcase
    r.trig     = trig;
    r.mode_led = !sonar;
    r.alarm    = alarm_on;
    r.distance = dist_cm;
    r.hund     = glyph((dist_cm % 1000) / 100);
    r.tens     = glyph((dist_cm % 100) / 10);
    r.units    = glyph(dist_cm % 10);
    r.fourth   = sonar ? '0 : SEG_DASH;
    r.done     = done;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] exp_val,
                             input logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_val, got_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_len    = TRIG_RESET;
      cm_per_tick = SCALE_RESET;
      ph          = PH_IDLE;
      ticks       = '0;
      sonar       = 1'b1;
      thr_cm      = THR_RESET;
      dist_cm     = '0;
      alarm_on    = 1'b0;
      view_q.delete();
      pending_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TRIGGER: trig_len    = cfg_wdata_i[TRIG_W-1:0];
          CFG_SCALE:   cm_per_tick = cfg_wdata_i[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (req_if.valid && req_if.ready) begin
        view_q.push_back(advance_ranger(opcode_e'(req_if.opcode), req_if.echo_level,
                                        req_if.adc_sample));
      end
      if (res_if.valid && res_if.ready) begin
        if (view_q.size() == 0) begin
          $display("%0t: result with no request waiting", $time);
          fail_count_o++;
        end else begin
          want = view_q.pop_front();
          check_field("trigger_out", want.trig, res_if.trigger_out);
          check_field("mode_led", want.mode_led, res_if.mode_led);
          check_field("alarm", want.alarm, res_if.alarm);
          check_field("shown_distance", want.distance, res_if.shown_distance);
          check_field("seg_hundreds", want.hund, res_if.seg_hundreds);
          check_field("seg_tens", want.tens, res_if.seg_tens);
          check_field("seg_units", want.units, res_if.seg_units);
          check_field("seg_fourth", want.fourth, res_if.seg_fourth);
          check_field("measure_done", want.done, res_if.measure_done);
        end
      end
      pending_o = view_q.size();
    end
  end

endmodule

// File: verif/testbench.sv
// top of the ultrasonic ranger testbench: clock, reset, stimulus, stalls and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import usrng_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int HOLD_CYCLES = 80;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  int                   fail_count;
  int                   pending;
  int                   req_count   = 0;
  int                   burst_left  = 0;
  int                   hold_asks   = 0;
  int                   idle_cycles = 0;
  logic [TRIG_W-1:0]    cur_trig    = TRIG_RESET;
  logic                 thr_mode    = 1'b0;

  usrng_in_if  req_if ();
  usrng_out_if res_if ();

  ultrasonic_ranger_with_threshold dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  usrng_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req_if       (req_if),
    .res_if       (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver stall pattern, plus a long hold-off on request
  initial begin : result_stall
    int stall_mode;
    int span;
    int hold_left;
    int hold_seen;
    stall_mode = 0;
    span       = 0;
    hold_left  = 0;
    hold_seen  = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (span == 0) begin
        stall_mode = $urandom_range(0, 2);
        span       = $urandom_range(16, 300);
      end
      span--;
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= ($urandom_range(0, 9) < 6);
          default: res_if.ready <= (span % 4 != 0);
        endcase
      end
    end
  end

  function automatic logic [ADC_WIDTH-1:0] rand_adc();
    return ADC_WIDTH'($urandom_range(0, (1 << ADC_WIDTH) - 1));
  endfunction

  task automatic send_req(input opcode_e op, input logic echo, input logic [ADC_WIDTH-1:0] adc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.echo_level <= echo;
    req_if.adc_sample <= adc;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    req_count++;
    if (op == OP_BUTTON) thr_mode = !thr_mode;
  endtask

  task automatic tick(input logic echo);
    send_req(OP_TICK, echo, rand_adc());
  endtask

  task automatic press_button();
    send_req(OP_BUTTON, 1'($urandom_range(0, 1)), rand_adc());
  endtask

  task automatic wait_drained(input int tail);
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (tail) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic set_ranger(input logic [TRIG_W-1:0] trig, input logic [SCALE_W-1:0] scale);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_TRIGGER;
    cfg_wdata_i <= CFG_W'(trig);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_SCALE;
    cfg_wdata_i <= CFG_W'(scale);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_trig = trig;
  endtask

  // full sonar cycle from idle: trigger, wait for rise, echo high, fall
  task automatic measure(input int echo_len);
    repeat ((cur_trig == 0) ? 1 : int'(cur_trig)) tick(1'($urandom_range(0, 1)));
    repeat ($urandom_range(0, 4)) tick(1'b0);
    repeat (echo_len) tick(1'b1);
    tick(1'b0);
  endtask

  // random requests, then back to sonar mode with the sequencer idle
  task automatic wander(input int n, input bit to_thr);
    opcode_e op;
    if (to_thr) press_button();
    repeat (n) begin
      op = (to_thr && $urandom_range(0, 1)) ? OP_ADC : opcode_e'($urandom_range(0, 3));
      send_req(op, 1'($urandom_range(0, 1)), rand_adc());
    end
    if (thr_mode) begin
      press_button();
    end else begin
      press_button();
      press_button();
    end
  endtask

  task automatic random_phase(input int n_items, input bit hold_once, input bit pause_once);
    int stop;
    stop = req_count + n_items;
    while (req_count < stop) begin
      if (req_count > stop - n_items / 2) begin
        if (hold_once) begin
          hold_asks <= hold_asks + 1;
          hold_once = 1'b0;
        end
        if (pause_once) begin
          wait_drained(4);
          pause_once = 1'b0;
        end
      end
      case ($urandom_range(0, 9))
        0: wander($urandom_range(1, 6), 1'b1);
        1: wander($urandom_range(1, 6), 1'b0);
        2: begin
          repeat ($urandom_range(1, 40)) tick(1'($urandom_range(0, 1)));
          press_button();
          press_button();
        end
        default: begin
          measure(($urandom_range(0, 19) == 0) ? $urandom_range(41, 2500)
                                                : $urandom_range(1, 40));
        end
      endcase
    end
  endtask

  initial begin
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_TRIGGER;
    cfg_wdata_i       <= '0;
    req_if.valid      <= 1'b0;
    req_if.opcode     <= OP_TICK;
    req_if.echo_level <= 1'b0;
    req_if.adc_sample <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // threshold mode and ignored requests at reset settings
    send_req(OP_NONE, 1'b1, '1);
    send_req(OP_ADC, 1'b0, '1);
    send_req(OP_BUTTON, 1'b0, '0);
    tick(1'b1);
    send_req(OP_ADC, 1'b0, '1);
    send_req(OP_ADC, 1'b1, '0);
    send_req(OP_ADC, 1'b0, ADC_WIDTH'(305));
    send_req(OP_NONE, 1'b0, '0);
    send_req(OP_BUTTON, 1'b1, '1);
    wait_drained(8);

    // short trigger, one echo, then a measurement abandoned by the button
    set_ranger(TRIG_W'(2), SCALE_RESET);
    tick(1'b1);
    tick(1'b0);
    tick(1'b0);
    tick(1'b1);
    tick(1'b1);
    tick(1'b0);
    tick(1'b1);
    press_button();
    press_button();
    wait_drained(8);

    // zero trigger length acts as one tick
    set_ranger('0, '1);
    measure(3);
    wait_drained(8);

    set_ranger(TRIG_RESET, SCALE_RESET);
    random_phase(300, 1'b1, 1'b0);
    wait_drained(8);
    set_ranger('0, '1);
    random_phase(250, 1'b0, 1'b0);
    wait_drained(8);
    set_ranger('1, '0);
    random_phase(150, 1'b0, 1'b0);
    wait_drained(8);
    set_ranger(TRIG_W'(1), SCALE_W'(32768));
    random_phase(200, 1'b0, 1'b1);
    wait_drained(8);

    // echo long enough to saturate the tick counter
    set_ranger(TRIG_W'(1), '1);
    measure(65540);
    wait_drained(8);

    set_ranger(TRIG_W'($urandom_range(1, 40)), SCALE_W'($urandom));
    random_phase(200, 1'b0, 1'b0);
    wait_drained(8);
    set_ranger(TRIG_W'($urandom_range(1, 20)), SCALE_W'($urandom));
    random_phase(200, 1'b1, 1'b0);
    wait_drained(12);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
